@@ rtl/hashed_value_noise_gust_defines.svh @@
// Assertion macros for the hvng_checker module.
`ifndef HASHED_VALUE_NOISE_GUST_DEFINES_SVH
`define HASHED_VALUE_NOISE_GUST_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define HVNG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hashed_value_noise_gust: assertion failed");

// Clocked property, also checked during reset.
`define HVNG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hashed_value_noise_gust: assertion failed");

`endif

@@ rtl/hvng_pkg.sv @@
package hvng_pkg;

  typedef logic [63:0] word_t;

  localparam int NumOct  = 3;
  localparam int NumLane = 2 * NumOct;
  localparam int NumStg  = 12;

  localparam word_t GoldenInc = 64'h9e3779b97f4a7c15;
  localparam word_t MulOne    = 64'hbf58476d1ce4e5b9;
  localparam word_t MulTwo    = 64'h94d049bb133111eb;
  localparam word_t MulB      = 64'hd6e8feb86659fd93;

  localparam logic [15:0] OctWeight [NumOct] = '{16'd32768, 16'd19661, 16'd13107};

  localparam logic [17:0] SmoothK  = 18'd196608;
  localparam logic [16:0] One16    = 17'd65536;
  localparam logic [35:0] RemapOff = 36'd1073741824;
  localparam logic [16:0] GustMax  = 17'd65536;

  // Key engine step codes.
  localparam logic [3:0] StAdd = 4'd0;
  localparam logic [3:0] StX30 = 4'd1;
  localparam logic [3:0] StM1A = 4'd2;
  localparam logic [3:0] StM1B = 4'd3;
  localparam logic [3:0] StM1C = 4'd4;
  localparam logic [3:0] StX27 = 4'd5;
  localparam logic [3:0] StM2A = 4'd6;
  localparam logic [3:0] StM2B = 4'd7;
  localparam logic [3:0] StM2C = 4'd8;
  localparam logic [3:0] StX31 = 4'd9;

endpackage

@@ rtl/hashed_value_noise_gust.sv @@
// Hashed value-noise gust factor.
//
// Request channel: drive position_i and raise start; the request is taken
// at a rising edge where start is high and busy is low. A new request
// may be taken every cycle, so one gust level per cycle is sustained.
// Result: gust_level_o is shown for exactly one cycle with gust_valid_o
// high, once the request has passed through the register stages; results come
// out in request order. The receiver cannot stall, and the pipeline never
// holds.
// Seed channel: cfg_valid_i/cfg_ready_o carry the 64-bit noise seed in
// cfg_data_i. Write it only while no request is in flight.
// After reset, and after each seed write, a key engine derives the three
// octave keys from the seed with one shared 32x32 multiplier: 4 hashes of
// 10 steps each. During that time busy is high, cfg_ready_o is low and
// no request is taken. Reset sets the seed to zero.
// Latency is set by the 12 register stages (the chained 64-bit constant
// multiplies, each split into 32-bit partial products over two stages).
module hashed_value_noise_gust #(
  parameter int FRAC_BITS     = 16,
  parameter int POSITION_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [POSITION_BITS-1:0] position_i,
  output logic                            gust_valid_o,
  output logic [16:0]                     gust_level_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  hvng_pkg::word_t                 cfg_data_i
);
  import hvng_pkg::*;

  // ---------------------------------------------------------------------
  // Key engine: key[o] = hash(hash(seed) ^ (o+1)), one step per cycle.
  // ---------------------------------------------------------------------
  logic        run_q, run_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  hidx_q, hidx_d;
  word_t       seed_q, seed_d;
  word_t       z_q, z_d;
  word_t       acc_q, acc_d;
  word_t       h0_q, h0_d;
  word_t       key_q [NumOct];
  word_t       key_d [NumOct];
  logic [31:0] eng_a, eng_b;
  logic [63:0] eng_p;
  word_t       eng_c;
  word_t       eng_in;
  word_t       eng_h;
  logic        cfg_wr;

  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = !run_q;
  assign busy        = run_q;

  always_comb begin
    eng_c = (step_q <= StX27) ? MulOne : MulTwo;
    case (step_q)
      StM1B, StM2B: begin
        eng_a = z_q[31:0];
        eng_b = eng_c[63:32];
      end
      StM1C, StM2C: begin
        eng_a = z_q[63:32];
        eng_b = eng_c[31:0];
      end
      default: begin
        eng_a = z_q[31:0];
        eng_b = eng_c[31:0];
      end
    endcase
    eng_p  = eng_a * eng_b;
    eng_in = (hidx_q == 2'd0) ? seed_q : (h0_q ^ {62'd0, hidx_q});
    eng_h  = acc_q ^ (acc_q >> 31);
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    hidx_d = hidx_q;
    seed_d = seed_q;
    z_d    = z_q;
    acc_d  = acc_q;
    h0_d   = h0_q;
    key_d  = key_q;
    if (run_q) begin
      step_d = step_q + 4'd1;
      case (step_q)
        StAdd: z_d = eng_in + GoldenInc;
        StX30: z_d = z_q ^ (z_q >> 30);
        StM1A, StM2A: acc_d = eng_p;
        StM1B, StM1C, StM2B, StM2C: acc_d = acc_q + {eng_p[31:0], 32'd0};
        StX27: z_d = acc_q ^ (acc_q >> 27);
        StX31: begin
          step_d = StAdd;
          if (hidx_q == 2'd0) begin
            h0_d = eng_h;
          end else begin
            key_d[hidx_q - 2'd1] = eng_h;
          end
          if (hidx_q == 2'(NumOct)) begin
            run_d = 1'b0;
          end
          hidx_d = hidx_q + 2'd1;
        end
        default: step_d = StAdd;
      endcase
    end else if (cfg_wr) begin
      seed_d = cfg_data_i;
      run_d  = 1'b1;
      step_d = StAdd;
      hidx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b1;
      step_q <= StAdd;
      hidx_q <= 2'd0;
      seed_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      hidx_q <= hidx_d;
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    acc_q <= acc_d;
    h0_q  <= h0_d;
    key_q <= key_d;
  end

  // ---------------------------------------------------------------------
  // Noise pipeline. Lane 2*o+s is octave o, cell (s=0) or next cell (s=1).
  // ---------------------------------------------------------------------
  logic [NumStg-1:0] vld_q, vld_d;
  logic              accept;

  assign accept = start && !busy;
  assign vld_d  = {vld_q[NumStg-2:0], accept};

  logic signed [63:0] pos_q, pos_d;
  word_t       cp0_q [NumOct], cp0_d [NumOct];
  logic [31:0] cp1_q [NumOct], cp1_d [NumOct];
  logic [31:0] cp2_q [NumOct], cp2_d [NumOct];
  logic [15:0] f2_q  [NumOct], f2_d  [NumOct];
  word_t       m3_q  [NumLane], m3_d [NumLane];
  logic [15:0] sq3_q [NumOct], sq3_d [NumOct];
  logic [15:0] f3_q  [NumOct];
  word_t       z4_q  [NumLane], z4_d [NumLane];
  logic [16:0] t4_q  [NumOct], t4_d [NumOct];
  word_t       p05_q [NumLane], p05_d [NumLane];
  logic [31:0] p15_q [NumLane], p15_d [NumLane];
  logic [31:0] p25_q [NumLane], p25_d [NumLane];
  logic [16:0] t5_q  [NumOct];
  word_t       z6_q  [NumLane], z6_d [NumLane];
  logic [16:0] t6_q  [NumOct];
  word_t       p07_q [NumLane], p07_d [NumLane];
  logic [31:0] p17_q [NumLane], p17_d [NumLane];
  logic [31:0] p27_q [NumLane], p27_d [NumLane];
  logic [16:0] t7_q  [NumOct];
  logic [15:0] lat8_q [NumLane], lat8_d [NumLane];
  logic [16:0] t8_q  [NumOct];
  logic [32:0] pa9_q [NumOct], pa9_d [NumOct];
  logic [32:0] pb9_q [NumOct], pb9_d [NumOct];
  logic [17:0] v10_q [NumOct], v10_d [NumOct];
  logic [33:0] w11_q [NumOct], w11_d [NumOct];
  logic [16:0] gust_q, gust_d;

  assign pos_d = 64'(position_i);

  always_comb begin
    int    fb;
    word_t cell_w;
    word_t y;
    word_t x;
    logic [31:0]  sq;
    logic [33:0]  tp;
    logic [33:0]  bs;
    logic [35:0]  sum;
    logic [35:0]  dif;
    for (int o = 0; o < NumOct; o++) begin
      // Split position into cell and fraction; begin cell * MulB.
      fb       = FRAC_BITS + 4 - o;
      cell_w   = word_t'(pos_q >>> fb);
      f2_d[o]  = (fb >= 16) ? 16'(pos_q >> (fb - 16)) : 16'(pos_q << (16 - fb));
      cp0_d[o] = cell_w[31:0] * MulB[31:0];
      cp1_d[o] = 32'(cell_w[31:0] * MulB[63:32]);
      cp2_d[o] = 32'(cell_w[63:32] * MulB[31:0]);
      // Finish the product; the next cell adds MulB once more.
      y              = cp0_q[o] + {cp1_q[o] + cp2_q[o], 32'd0};
      m3_d[2*o]      = y;
      m3_d[2*o+1]    = y + MulB;
      sq             = f2_q[o] * f2_q[o];
      sq3_d[o]       = sq[31:16];
      // Smoothstep weight.
      tp       = sq3_q[o] * (SmoothK - {1'b0, f3_q[o], 1'b0});
      t4_d[o]  = tp[32:16];
      // Blend the two lattice values.
      pa9_d[o] = lat8_q[2*o] * (One16 - t8_q[o]);
      pb9_d[o] = lat8_q[2*o+1] * t8_q[o];
      bs       = 34'(pa9_q[o]) + 34'(pb9_q[o]);
      v10_d[o] = bs[33:16];
      w11_d[o] = v10_q[o] * OctWeight[o];
    end
    for (int l = 0; l < NumLane; l++) begin
      x        = (key_q[l/2] ^ m3_q[l]) + GoldenInc;
      z4_d[l]  = x ^ (x >> 30);
      p05_d[l] = z4_q[l][31:0] * MulOne[31:0];
      p15_d[l] = 32'(z4_q[l][31:0] * MulOne[63:32]);
      p25_d[l] = 32'(z4_q[l][63:32] * MulOne[31:0]);
      y        = p05_q[l] + {p15_q[l] + p25_q[l], 32'd0};
      z6_d[l]  = y ^ (y >> 27);
      p07_d[l] = z6_q[l][31:0] * MulTwo[31:0];
      p17_d[l] = 32'(z6_q[l][31:0] * MulTwo[63:32]);
      p27_d[l] = 32'(z6_q[l][63:32] * MulTwo[31:0]);
      y        = p07_q[l] + {p17_q[l] + p27_q[l], 32'd0};
      x        = y ^ (y >> 31);
      lat8_d[l] = x[63:48];
    end
    // Weighted sum, remap by (n - 0.25) * 2, saturate.
    sum = 36'(w11_q[0]) + 36'(w11_q[1]) + 36'(w11_q[2]);
    dif = sum - RemapOff;
    if (sum <= RemapOff) begin
      gust_d = '0;
    end else if (dif[35:15] > 21'(GustMax)) begin
      gust_d = GustMax;
    end else begin
      gust_d = dif[31:15];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cp0_q  <= cp0_d;
    cp1_q  <= cp1_d;
    cp2_q  <= cp2_d;
    f2_q   <= f2_d;
    m3_q   <= m3_d;
    sq3_q  <= sq3_d;
    f3_q   <= f2_q;
    z4_q   <= z4_d;
    t4_q   <= t4_d;
    p05_q  <= p05_d;
    p15_q  <= p15_d;
    p25_q  <= p25_d;
    t5_q   <= t4_q;
    z6_q   <= z6_d;
    t6_q   <= t5_q;
    p07_q  <= p07_d;
    p17_q  <= p17_d;
    p27_q  <= p27_d;
    t7_q   <= t6_q;
    lat8_q <= lat8_d;
    t8_q   <= t7_q;
    pa9_q  <= pa9_d;
    pb9_q  <= pb9_d;
    v10_q  <= v10_d;
    w11_q  <= w11_d;
    gust_q <= gust_d;
  end

  assign gust_valid_o = vld_q[NumStg-1];
  assign gust_level_o = gust_q;

endmodule

@@ rtl/hvng_checker.sv @@
`include "hashed_value_noise_gust_defines.svh"

module hvng_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        gust_valid_o,
  input logic [16:0] gust_level_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  `HVNG_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##12 gust_valid_o)
  `HVNG_ASSERT(a_seed_busy, clk_i, rst_ni, (cfg_valid_i && cfg_ready_o) |=> busy)
  `HVNG_ASSERT(a_range, clk_i, rst_ni, gust_valid_o |-> (gust_level_o <= 17'd65536))
  `HVNG_ASSERT(a_ready_busy, clk_i, rst_ni, cfg_ready_o == !busy)
  `HVNG_ASSERT_ALWAYS(a_reset_busy, clk_i, !rst_ni |=> busy)

endmodule

bind hashed_value_noise_gust hvng_checker u_hvng_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .gust_valid_o (gust_valid_o),
  .gust_level_o (gust_level_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);

@@ bench/gust_checker.sv @@
module gust_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic signed [47:0]  position_i,
  input  logic                gust_valid_i,
  input  logic [16:0]         gust_level_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  hvng_pkg::word_t     cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import hvng_pkg::*;

  word_t       seed_q;
  logic [16:0] gust_queue[$];

  function automatic word_t mix64(word_t z);
    z = z + GoldenInc;
    z = (z ^ (z >> 30)) * MulOne;
    z = (z ^ (z >> 27)) * MulTwo;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] lattice(word_t seed, word_t oct, word_t cell_num);
    word_t z;
    z = mix64(mix64(mix64(seed) ^ oct) ^ (cell_num * MulB));
    return {48'd0, z[63:48]};
  endfunction

  function automatic logic [63:0] octave(word_t seed, logic signed [63:0] pos,
                                         word_t oct, int shift);
    logic signed [63:0] cell_num;
    logic [63:0] f, a, b, t;
    cell_num = pos >>> (16 + shift);
    f = (pos >> shift) & 64'hFFFF;
    a = lattice(seed, oct, cell_num);
    b = lattice(seed, oct, cell_num + 64'd1);
    t = (((f * f) >> 16) * (64'd196608 - 2 * f)) >> 16;
    return (a * (64'd65536 - t) + b * t) >> 16;
  endfunction

  function automatic logic [16:0] predict_gust(word_t seed, logic signed [47:0] p);
    logic signed [63:0] pos;
    logic [63:0] sum, r;
    pos = p;
    sum = 64'd32768 * octave(seed, pos, 1, 4) + 64'd19661 * octave(seed, pos, 2, 3)
        + 64'd13107 * octave(seed, pos, 3, 2);
    if (sum <= 64'd1073741824) r = 0;
    else begin
      r = (sum - 64'd1073741824) >> 15;
      if (r > 65536) r = 65536;
    end
    return r[16:0];
  endfunction

  assign pending_o = gust_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      fail_count_o <= 0;
      gust_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) seed_q <= cfg_data_i;
      // Queue the request before the compare, so a result in the same cycle would still match.
      if (start_i && !busy_i) gust_queue.push_back(predict_gust(seed_q, position_i));
      if (gust_valid_i) begin
        if (gust_queue.size() == 0) begin
          $error("unexpected gust_level %0d", gust_level_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          logic [16:0] expected_gust;
          expected_gust = gust_queue.pop_front();
          if (expected_gust !== gust_level_i) begin
            $error("gust_level expected %0d actual %0d", expected_gust, gust_level_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/testbench.sv @@
module testbench;
  import hvng_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [47:0] position_i = '0;
  logic               gust_valid_o;
  logic [16:0]        gust_level_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  word_t              cfg_data_i = '0;
  int                 fail_count;
  int                 pending;

  always #5 clk_i = ~clk_i;

  hashed_value_noise_gust i_dut (
    .clk_i, .rst_ni, .start(start_i), .busy(busy_o), .position_i,
    .gust_valid_o, .gust_level_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  gust_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .position_i,
    .gust_valid_i(gust_valid_o), .gust_level_i(gust_level_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Hold one request on the port until the block takes it.
  task automatic send_request(logic signed [47:0] pos);
    start_i    <= 1'b1;
    position_i <= pos;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Lower start and wait out the given number of clock edges.
  task automatic idle_gap(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain the pipeline, then write the seed; requests sent next wait out the key engine.
  task automatic write_seed(word_t seed);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small positions near zero, some spread across the full range.
  function automatic logic signed [47:0] random_position();
    case ($urandom_range(0, 3))
      0:       return 48'({$urandom(), $urandom()});
      1:       return $signed({{16{1'b0}}, 32'($urandom())}) - 48'sd2147483648;
      2:       return {{30{$urandom_range(0, 1) == 1}}, 18'($urandom())};
      default: return 48'($signed($urandom_range(0, 4000000))) - 48'sd2000000;
    endcase
  endfunction

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    word_t seeds[5];
    logic signed [47:0] directed[$];
    seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
              64'h8000_0000_0000_0001, 64'hDEAD_BEEF_0BAD_F00D};
    directed = '{48'sh7FFF_FFFF_FFFF, -48'sh8000_0000_0000, 48'sd0, -48'sd1, 48'sd1,
                 48'sd65535, 48'sd65536, -48'sd65536, 48'sh0F_FFFF, 48'sh10_0000,
                 48'sh7FFF_FFF0_0000, -48'sh7FFF_FFF0_0000, 48'sh5555_5555_5555,
                 -48'sh5555_5555_5556, 48'sh8_8000, 48'sh4_4000, 48'sh2_2000,
                 48'sh3FFF, 48'sh7FFF_FFFF_0000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Default seed first, then each seed: directed burst plus random traffic.
    foreach (seeds[s]) begin
      if (s != 0) write_seed(seeds[s]);
      foreach (directed[d]) send_request(directed[d]);
      for (int n = 0; n < 280; n++) begin
        send_request(random_position());
        if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 14));
      end
      idle_gap(0);
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hvng_pkg.sv
rtl/hashed_value_noise_gust.sv
rtl/hvng_checker.sv
bench/gust_checker.sv
bench/testbench.sv
